[rtl/csaa_pkg.sv]
// Package: widths, queue entry type and saturating add shared by the area accumulator.
`default_nettype none
package csaa_pkg;

    localparam int COORD_BITS    = 24;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int TERM_BITS     = 2 * DIFF_BITS;
    localparam int ACC_BITS      = 64;
    localparam int AREA_BITS     = ACC_BITS - 1;
    localparam int ID_BITS       = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    // One closed segment, already reduced to the operands of its two trapezoid terms.
    typedef struct packed {
        logic signed [DIFF_BITS-1:0] seg_dx;
        logic signed [DIFF_BITS-1:0] seg_sy;
        logic signed [DIFF_BITS-1:0] close_dx;
        logic signed [DIFF_BITS-1:0] close_sy;
        logic                        start;
        logic                        last;
        logic [ID_BITS-1:0]          id;
    } t_csaa_entry;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] sum;
        logic                       clip;
    } t_csaa_sat;

    function automatic t_csaa_sat sat_add(input logic signed [ACC_BITS-1:0] a,
                                          input logic signed [ACC_BITS-1:0] b);
        logic [ACC_BITS:0] s;
        t_csaa_sat         r;
        s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            r.clip = 1'b1;
            r.sum  = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                 : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            r.clip = 1'b0;
            r.sum  = s[ACC_BITS-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/csaa_if.sv]
// Interfaces: segment input channel and area result channel.
`default_nettype none
interface csaa_seg_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [csaa_pkg::COORD_BITS-1:0]     start_x;
    logic signed [csaa_pkg::COORD_BITS-1:0]     start_y;
    logic [csaa_pkg::ID_BITS-1:0]               contour_id;
    logic                                       is_closed;
    logic                                       last_of_contour;

    modport source (output valid, start_x, start_y, contour_id, is_closed, last_of_contour,
                    input ready);
    modport sink (input valid, start_x, start_y, contour_id, is_closed, last_of_contour,
                  output ready);
endinterface

interface csaa_area_if;
    logic                                       valid;
    logic                                       ready;
    logic [csaa_pkg::ID_BITS-1:0]               area_contour_id;
    logic signed [csaa_pkg::AREA_BITS-1:0]      signed_area;
    logic                                       clockwise;
    logic                                       counter_clockwise;
    logic                                       saturated;

    modport source (output valid, area_contour_id, signed_area, clockwise,
                    counter_clockwise, saturated, input ready);
    modport sink (input valid, area_contour_id, signed_area, clockwise,
                  counter_clockwise, saturated, output ready);
endinterface
`default_nettype wire

[rtl/contour_signed_area_accumulator_unit.sv]
// Top level: signed shoelace area of closed contours from a segment stream.
//
//  channel   dir  beat carries
//  i_seg     in   start_x, start_y, contour_id, is_closed, last_of_contour
//  o_area    out  area_contour_id, signed_area, clockwise, counter_clockwise, saturated
//
// Takes one segment per cycle while the queue has room; the rate is set by the 64-bit saturating
// accumulator, which closes one add per cycle.
// A result is formed via the multiply, closing, halving and result registers.
// Synchronous active-low reset clears the contour and pipeline state; no clearing pass.
// A stalled result holds the back end only; the four-entry queue keeps the input
// open until it fills. Open segments are taken and dropped.
`default_nettype none
module contour_signed_area_accumulator_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    csaa_seg_if.sink    i_seg,
    csaa_area_if.source o_area
);

    csaa_pkg::t_csaa_entry w_push_data;
    logic                  w_push_valid;
    logic                  w_push_ready;
    csaa_pkg::t_csaa_entry w_pop_data;
    logic                  w_pop_valid;
    logic                  w_pop_ready;

    csaa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (i_seg),
        .o_push_data  (w_push_data),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready)
    );

    csaa_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  (w_push_data),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_data   (w_pop_data),
        .i_pop_ready  (w_pop_ready)
    );

    csaa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_data  (w_pop_data),
        .o_pop_ready (w_pop_ready),
        .o_area      (o_area)
    );

    // The front end never offers a segment the queue cannot take.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> w_push_ready)
        else $error("segment pushed into full queue");

    // A positive sum never reports a negative area.
    a_cw_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_area.valid && o_area.clockwise) |->
            !o_area.signed_area[csaa_pkg::AREA_BITS-1])
        else $error("clockwise result with negative area");

    // A negative sum reports a negative area or zero.
    a_ccw_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_area.valid && o_area.counter_clockwise) |->
            (o_area.signed_area[csaa_pkg::AREA_BITS-1] || (o_area.signed_area == '0)))
        else $error("counter-clockwise result with positive area");

    // Orientation flags are exclusive.
    a_orient_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_area.valid |-> !(o_area.clockwise && o_area.counter_clockwise))
        else $error("both orientation flags set");

endmodule
`default_nettype wire

[rtl/csaa_front.sv]
// Front end: accepts segments, drops open ones, tracks first and previous points.
`default_nettype none
module csaa_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    csaa_seg_if.sink                i_seg,
    output csaa_pkg::t_csaa_entry   o_push_data,
    output logic                    o_push_valid,
    input  wire logic               i_push_ready
);

    logic                                   r_in_contour;
    logic signed [csaa_pkg::COORD_BITS-1:0] r_first_x;
    logic signed [csaa_pkg::COORD_BITS-1:0] r_first_y;
    logic signed [csaa_pkg::COORD_BITS-1:0] r_prev_x;
    logic signed [csaa_pkg::COORD_BITS-1:0] r_prev_y;

    logic                                   w_accept;
    logic                                   w_take;
    logic signed [csaa_pkg::COORD_BITS-1:0] w_first_x;
    logic signed [csaa_pkg::COORD_BITS-1:0] w_first_y;

    assign i_seg.ready = i_push_ready;
    assign w_accept    = i_seg.valid && i_seg.ready;
    assign w_take      = w_accept && i_seg.is_closed;

    // A contour's first segment is its own first point.
    assign w_first_x = r_in_contour ? r_first_x : i_seg.start_x;
    assign w_first_y = r_in_contour ? r_first_y : i_seg.start_y;

    always_comb begin
        o_push_valid         = w_take;
        o_push_data.start    = !r_in_contour;
        o_push_data.last     = i_seg.last_of_contour;
        o_push_data.id       = i_seg.contour_id;
        if (r_in_contour) begin
            o_push_data.seg_dx = csaa_pkg::DIFF_BITS'(i_seg.start_x)
                               - csaa_pkg::DIFF_BITS'(r_prev_x);
            o_push_data.seg_sy = csaa_pkg::DIFF_BITS'(i_seg.start_y)
                               + csaa_pkg::DIFF_BITS'(r_prev_y);
        end else begin
            o_push_data.seg_dx = '0;
            o_push_data.seg_sy = '0;
        end
        o_push_data.close_dx = csaa_pkg::DIFF_BITS'(w_first_x)
                             - csaa_pkg::DIFF_BITS'(i_seg.start_x);
        o_push_data.close_sy = csaa_pkg::DIFF_BITS'(w_first_y)
                             + csaa_pkg::DIFF_BITS'(i_seg.start_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_contour <= 1'b0;
        end else if (w_take) begin
            r_in_contour <= !i_seg.last_of_contour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_first_x <= w_first_x;
            r_first_y <= w_first_y;
            r_prev_x  <= i_seg.start_x;
            r_prev_y  <= i_seg.start_y;
        end
    end

endmodule
`default_nettype wire

[rtl/csaa_fifo.sv]
// Short queue of classified segments between front end and accumulator.
`default_nettype none
module csaa_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push_valid,
    input  wire csaa_pkg::t_csaa_entry  i_push_data,
    output logic                        o_push_ready,
    output logic                        o_pop_valid,
    output csaa_pkg::t_csaa_entry       o_pop_data,
    input  wire logic                   i_pop_ready
);

    csaa_pkg::t_csaa_entry              r_mem [csaa_pkg::FIFO_DEPTH];
    logic [csaa_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [csaa_pkg::FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [csaa_pkg::FIFO_PTR_BITS:0]   r_count;
    logic                               w_push;
    logic                               w_pop;

    assign o_push_ready = r_count != (csaa_pkg::FIFO_PTR_BITS+1)'(csaa_pkg::FIFO_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

[rtl/csaa_back.sv]
// Back end: products, saturating accumulator, closing term, halving and result register.
`default_nettype none
module csaa_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_pop_valid,
    input  wire csaa_pkg::t_csaa_entry  i_pop_data,
    output logic                        o_pop_ready,
    csaa_area_if.source                 o_area
);

    logic                                   w_en;

    // multiply stage
    logic                                   r_m_valid;
    logic signed [csaa_pkg::TERM_BITS-1:0]  r_m_t1;
    logic signed [csaa_pkg::TERM_BITS-1:0]  r_m_t2;
    logic                                   r_m_start;
    logic                                   r_m_last;
    logic [csaa_pkg::ID_BITS-1:0]           r_m_id;
    logic signed [csaa_pkg::TERM_BITS-1:0]  w_t1;
    logic signed [csaa_pkg::TERM_BITS-1:0]  w_t2;

    // accumulator loop
    logic signed [csaa_pkg::ACC_BITS-1:0]   r_acc;
    logic                                   r_clip;
    logic signed [csaa_pkg::ACC_BITS-1:0]   w_acc_base;
    logic                                   w_clip_base;
    csaa_pkg::t_csaa_sat                    w_acc_sum;

    // closing stage
    logic                                   r_c_valid;
    logic signed [csaa_pkg::ACC_BITS-1:0]   r_c_acc;
    logic                                   r_c_clip;
    logic signed [csaa_pkg::TERM_BITS-1:0]  r_c_t2;
    logic [csaa_pkg::ID_BITS-1:0]           r_c_id;
    csaa_pkg::t_csaa_sat                    w_close_sum;

    // halving stage
    logic                                   r_d_valid;
    logic signed [csaa_pkg::ACC_BITS-1:0]   r_d_sum;
    logic                                   r_d_clip;
    logic [csaa_pkg::ID_BITS-1:0]           r_d_id;
    logic [csaa_pkg::ACC_BITS-1:0]          w_adj;

    // result register
    logic                                   r_o_valid;
    logic [csaa_pkg::ID_BITS-1:0]           r_o_id;
    logic signed [csaa_pkg::AREA_BITS-1:0]  r_o_area;
    logic                                   r_o_cw;
    logic                                   r_o_ccw;
    logic                                   r_o_sat;

    // Hold the whole back end while a result beat waits.
    assign w_en        = !r_o_valid || o_area.ready;
    assign o_pop_ready = w_en;

    assign w_t1 = i_pop_data.seg_dx * i_pop_data.seg_sy;
    assign w_t2 = i_pop_data.close_dx * i_pop_data.close_sy;

    assign w_acc_base  = r_m_start ? '0 : r_acc;
    assign w_clip_base = r_m_start ? 1'b0 : r_clip;
    assign w_acc_sum   = csaa_pkg::sat_add(w_acc_base, csaa_pkg::ACC_BITS'(r_m_t1));
    assign w_close_sum = csaa_pkg::sat_add(r_c_acc, csaa_pkg::ACC_BITS'(r_c_t2));

    // Round toward zero: bump negative sums by one before dropping the low bit.
    assign w_adj = r_d_sum + {{(csaa_pkg::ACC_BITS-1){1'b0}}, r_d_sum[csaa_pkg::ACC_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
            r_clip    <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= i_pop_valid;
            r_c_valid <= r_m_valid && r_m_last;
            r_d_valid <= r_c_valid;
            r_o_valid <= r_d_valid;
            if (r_m_valid) begin
                r_acc  <= w_acc_sum.sum;
                r_clip <= w_clip_base || w_acc_sum.clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_t1    <= w_t1;
            r_m_t2    <= w_t2;
            r_m_start <= i_pop_data.start;
            r_m_last  <= i_pop_data.last;
            r_m_id    <= i_pop_data.id;

            r_c_acc   <= w_acc_sum.sum;
            r_c_clip  <= w_clip_base || w_acc_sum.clip;
            r_c_t2    <= r_m_t2;
            r_c_id    <= r_m_id;

            r_d_sum   <= w_close_sum.sum;
            r_d_clip  <= r_c_clip || w_close_sum.clip;
            r_d_id    <= r_c_id;

            r_o_id    <= r_d_id;
            r_o_area  <= w_adj[csaa_pkg::ACC_BITS-1:1];
            r_o_cw    <= !r_d_sum[csaa_pkg::ACC_BITS-1] && (r_d_sum != '0);
            r_o_ccw   <= r_d_sum[csaa_pkg::ACC_BITS-1];
            r_o_sat   <= r_d_clip;
        end
    end

    assign o_area.valid             = r_o_valid;
    assign o_area.area_contour_id   = r_o_id;
    assign o_area.signed_area       = r_o_area;
    assign o_area.clockwise         = r_o_cw;
    assign o_area.counter_clockwise = r_o_ccw;
    assign o_area.saturated         = r_o_sat;

endmodule
`default_nettype wire

[sim/csaa_area_checker.sv]
// Checker: tracks segment beats, predicts each contour's signed area and compares result beats.
module csaa_area_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    csaa_seg_if       i_seg,
    csaa_area_if      i_area,
    output int        o_err_count,
    output int        o_open_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN    = 64'h8000_0000_0000_0000;
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic [csaa_pkg::ID_BITS-1:0]          id;
        logic signed [csaa_pkg::AREA_BITS-1:0] area;
        logic                                  cw;
        logic                                  ccw;
        logic                                  sat;
    } t_area_rec;

    t_area_rec pending_areas[$];

    logic   in_contour;
    longint first_x;
    longint first_y;
    longint prev_x;
    longint prev_y;
    longint twice_area;
    logic   clip_seen;
    int     err_cnt;

    initial begin
        err_cnt        = 0;
        o_err_count    = 0;
        o_open_results = 0;
    end

    // Clamp at the 64-bit rails and remember that it happened.
    function void add_trapezoid(input longint term);
        if (term > 0 && twice_area > SUM_MAX - term) begin
            twice_area = SUM_MAX;
            clip_seen  = 1'b1;
        end else if (term < 0 && twice_area < SUM_MIN - term) begin
            twice_area = SUM_MIN;
            clip_seen  = 1'b1;
        end else begin
            twice_area = twice_area + term;
        end
    endfunction

    task automatic trace_segment(input logic signed [csaa_pkg::COORD_BITS-1:0] sx,
                                 input logic signed [csaa_pkg::COORD_BITS-1:0] sy,
                                 input logic [csaa_pkg::ID_BITS-1:0]           id,
                                 input logic                                   closed,
                                 input logic                                   last);
        longint    x;
        longint    y;
        longint    half;
        t_area_rec rec;
        if (!closed) return;
        x = sx;
        y = sy;
        if (!in_contour) begin
            in_contour = 1'b1;
            first_x    = x;
            first_y    = y;
            twice_area = 0;
            clip_seen  = 1'b0;
        end else begin
            add_trapezoid((x - prev_x) * (y + prev_y));
        end
        prev_x = x;
        prev_y = y;
        if (!last) return;
        add_trapezoid((first_x - x) * (first_y + y));
        // Signed divide truncates toward zero; flags follow the full sum.
        half     = twice_area / 2;
        rec.id   = id;
        rec.area = half[csaa_pkg::AREA_BITS-1:0];
        rec.cw   = twice_area > 0;
        rec.ccw  = twice_area < 0;
        rec.sat  = clip_seen;
        pending_areas.push_back(rec);
        in_contour = 1'b0;
        twice_area = 0;
        clip_seen  = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_area_rec want;
        t_area_rec got;
        if (!i_rst_n) begin
            in_contour = 1'b0;
            first_x    = 0;
            first_y    = 0;
            prev_x     = 0;
            prev_y     = 0;
            twice_area = 0;
            clip_seen  = 1'b0;
            pending_areas.delete();
        end else begin
            if (i_seg.valid && i_seg.ready)
                trace_segment(i_seg.start_x, i_seg.start_y, i_seg.contour_id,
                              i_seg.is_closed, i_seg.last_of_contour);
            if (i_area.valid && i_area.ready) begin
                got.id   = i_area.area_contour_id;
                got.area = i_area.signed_area;
                got.cw   = i_area.clockwise;
                got.ccw  = i_area.counter_clockwise;
                got.sat  = i_area.saturated;
                if (pending_areas.size() == 0) begin
                    if (err_cnt < REPORT_MAX)
                        $display("%t: unexpected area beat id=%0d area=%0d cw=%0b ccw=%0b sat=%0b",
                                 $realtime, got.id, got.area, got.cw, got.ccw, got.sat);
                    err_cnt++;
                end else begin
                    want = pending_areas.pop_front();
                    if (got.id !== want.id || got.area !== want.area || got.cw !== want.cw ||
                        got.ccw !== want.ccw || got.sat !== want.sat) begin
                        if (err_cnt < REPORT_MAX) begin
                            $display("%t: area mismatch", $realtime);
                            $display("  exp id=%0d area=%0d cw=%0b ccw=%0b sat=%0b",
                                     want.id, want.area, want.cw, want.ccw, want.sat);
                            $display("  got id=%0d area=%0d cw=%0b ccw=%0b sat=%0b",
                                     got.id, got.area, got.cw, got.ccw, got.sat);
                        end
                        err_cnt++;
                    end
                end
            end
        end
        o_err_count    <= err_cnt;
        o_open_results <= pending_areas.size();
    end

endmodule

[sim/tb_contour_signed_area_accumulator_unit.sv]
// Testbench top: clock, reset, segment stimulus, result back-pressure and the verdict.
module tb_contour_signed_area_accumulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BEATS  = 110;

    localparam logic signed [csaa_pkg::COORD_BITS-1:0] C_MAX =
        {1'b0, {(csaa_pkg::COORD_BITS-1){1'b1}}};
    localparam logic signed [csaa_pkg::COORD_BITS-1:0] C_MIN =
        {1'b1, {(csaa_pkg::COORD_BITS-1){1'b0}}};

    localparam logic CLOSED = 1'b1;
    localparam logic OPEN   = 1'b0;
    localparam logic LAST   = 1'b1;
    localparam logic MORE   = 1'b0;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int tx_idle_pct = 11;
    int rx_idle_pct = 51;
    bit hold_toggle = 1'b0;
    int closed_beats = 0;
    int cycle_cnt = 0;
    int err_count;
    int open_results;

    csaa_seg_if  seg_if ();
    csaa_area_if area_if ();

    contour_signed_area_accumulator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if),
        .o_area  (area_if)
    );

    csaa_area_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seg          (seg_if),
        .i_area         (area_if),
        .o_err_count    (err_count),
        .o_open_results (open_results)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on each toggle request.
    initial begin
        bit seen_toggle;
        int hold_left;
        seen_toggle = 1'b0;
        hold_left   = 0;
        area_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                area_if.ready <= 1'b0;
                hold_left--;
            end else begin
                area_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_seg(input logic signed [csaa_pkg::COORD_BITS-1:0] x,
                            input logic signed [csaa_pkg::COORD_BITS-1:0] y,
                            input logic [csaa_pkg::ID_BITS-1:0]           id,
                            input logic                                   closed,
                            input logic                                   last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            seg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_if.valid           <= 1'b1;
        seg_if.start_x         <= x;
        seg_if.start_y         <= y;
        seg_if.contour_id      <= id;
        seg_if.is_closed       <= closed;
        seg_if.last_of_contour <= last;
        @(posedge i_clk);
        while (!seg_if.ready) @(posedge i_clk);
        if (closed) closed_beats++;
    endtask

    function automatic logic [csaa_pkg::COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return C_MAX;
            1:       return C_MIN;
            2, 3:    return csaa_pkg::COORD_BITS'($urandom_range(0, 400))
                          - csaa_pkg::COORD_BITS'(200);
            default: return csaa_pkg::COORD_BITS'($urandom());
        endcase
    endfunction

    // Mostly well-formed contours; sprinkle open beats and id changes inside them.
    task automatic random_contour();
        int                           len;
        int                           k;
        logic [csaa_pkg::ID_BITS-1:0] id;
        id  = csaa_pkg::ID_BITS'($urandom());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_seg(pick_coord(), pick_coord(), csaa_pkg::ID_BITS'($urandom()), OPEN,
                         logic'($urandom_range(0, 1)));
            if ($urandom_range(0, 15) == 0) id = csaa_pkg::ID_BITS'($urandom());
            send_seg(pick_coord(), pick_coord(), id, CLOSED, (k == len - 1) ? LAST : MORE);
        end
    endtask

    initial begin
        int base;
        int k;
        seg_if.valid           <= 1'b0;
        seg_if.start_x         <= '0;
        seg_if.start_y         <= '0;
        seg_if.contour_id      <= '0;
        seg_if.is_closed       <= 1'b0;
        seg_if.last_of_contour <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-segment contours: zero area, no orientation.
        send_seg('0, '0, 16'h0000, CLOSED, LAST);
        send_seg(C_MAX, C_MIN, 16'hFFFF, CLOSED, LAST);
        // Square both ways round.
        send_seg(24'sd0,   24'sd0,   16'd1, CLOSED, MORE);
        send_seg(24'sd100, 24'sd0,   16'd1, CLOSED, MORE);
        send_seg(24'sd100, 24'sd100, 16'd1, CLOSED, MORE);
        send_seg(24'sd0,   24'sd100, 16'd1, CLOSED, LAST);
        send_seg(24'sd0,   24'sd0,   16'd2, CLOSED, MORE);
        send_seg(24'sd0,   24'sd100, 16'd2, CLOSED, MORE);
        send_seg(24'sd100, 24'sd100, 16'd2, CLOSED, MORE);
        send_seg(24'sd100, 24'sd0,   16'd2, CLOSED, LAST);
        // Unit triangles: sum of -1 and +1, area 0 with a flag set.
        send_seg(24'sd0, 24'sd0, 16'd3, CLOSED, MORE);
        send_seg(24'sd1, 24'sd0, 16'd3, CLOSED, MORE);
        send_seg(24'sd0, 24'sd1, 16'd3, CLOSED, LAST);
        send_seg(24'sd0, 24'sd0, 16'd4, CLOSED, MORE);
        send_seg(24'sd0, 24'sd1, 16'd4, CLOSED, MORE);
        send_seg(24'sd1, 24'sd0, 16'd4, CLOSED, LAST);
        // Open beats between contours are dropped, even when flagged last.
        send_seg(24'sd5, 24'sd5, 16'd7, OPEN, LAST);
        send_seg(C_MIN, C_MAX, 16'h8001, OPEN, MORE);
        // Extreme triangle with an open beat and id changes inside it.
        send_seg(C_MIN, C_MIN, 16'h00A5, CLOSED, MORE);
        send_seg(C_MAX, C_MAX, 16'h1234, OPEN, LAST);
        send_seg(C_MAX, C_MIN, 16'h5A00, CLOSED, MORE);
        send_seg(C_MAX, C_MAX, 16'h5A5A, CLOSED, LAST);

        base = closed_beats;
        while (closed_beats < base + PHASE_BEATS) random_contour();

        tx_idle_pct = 51;
        rx_idle_pct = 11;
        base = closed_beats;
        while (closed_beats < base + PHASE_BEATS) random_contour();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        base = closed_beats;
        while (closed_beats < base + PHASE_BEATS) random_contour();

        // Hold the result side off and offer 40 one-beat contours so that the input stalls.
        hold_toggle <= ~hold_toggle;
        for (k = 0; k < 40; k++)
            send_seg(pick_coord(), pick_coord(), csaa_pkg::ID_BITS'($urandom()), CLOSED, LAST);

        seg_if.valid <= 1'b0;
        @(posedge i_clk);
        while (open_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && open_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
